/* hw/rtl/per_channel_range_error_estimator_defines.svh */
// Assertion macros for the range error estimator checker.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef PER_CHANNEL_RANGE_ERROR_ESTIMATOR_DEFINES_SVH
`define PER_CHANNEL_RANGE_ERROR_ESTIMATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCREE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCREE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pcree_pkg.sv */
package pcree_pkg;

	// field widths
	localparam int unsigned CH_BITS       = 10;
	localparam int unsigned WEIGHT_BITS   = 16;
	localparam int unsigned ACT_BITS      = 16;
	localparam int unsigned ADDS_BITS     = 32;
	localparam int unsigned NCH_BITS      = 11;
	localparam int unsigned RANGE_BITS    = 26;
	localparam int unsigned PEAK_BITS     = 16;
	localparam int unsigned EST_BITS      = 63;
	localparam int unsigned CFG_IDX_BITS  = 2;
	localparam int unsigned CFG_DATA_BITS = 32;

	// final arithmetic: base term and its split for the last multiply
	localparam int unsigned BASE_BITS = 44;
	localparam int unsigned BASE_HALF = BASE_BITS / 2;

	// per-entry epoch tag
	localparam int unsigned             EPOCH_BITS  = 4;
	localparam logic [EPOCH_BITS-1:0]   EPOCH_NONE  = '0;
	localparam logic [EPOCH_BITS-1:0]   EPOCH_FIRST = EPOCH_BITS'(1);
	localparam logic [EPOCH_BITS-1:0]   EPOCH_LAST  = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_ACT_MIN = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ACT_MAX = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ADDS    = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NCH     = 2'd3;

	// configuration reset values
	localparam logic [ADDS_BITS-1:0] ADDS_RESET = ADDS_BITS'(1);
	localparam logic [NCH_BITS-1:0]  NCH_RESET  = NCH_BITS'(1024);

	typedef struct packed {
		logic accept;
		logic update;
		logic sweep;
		logic mul1;
		logic mul2;
		logic sum;
		logic mul3;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic last_item;
		logic out_free;
		logic epoch_wrap;
	} sts_t;

endpackage

/* hw/rtl/per_channel_range_error_estimator.sv */
// Per-channel range error estimator. Weights arrive one per transaction, each tagged with its
// output channel; the block tracks the minimum and maximum of every channel in a RAM, keeps a
// saturating sum of channel ranges and the peak absolute weight, and on the weight marked last
// returns one result: (range_sum * max(|act_max|,|act_min|) + peak * num_channels *
// |act_max - act_min|) * accum_count, saturated at 2^63-1, together with range_sum and
// peak_weight. State is cleared after that result. For each weight its channel's entry is read
// from the RAM and the updated entry is written back. A last weight then passes through the mul1,
// mul2, sum and mul3 steps before the result is loaded into the output register once it is free;
// the register holds it while the next tensor's weights stream in. Channel entries carry a 4-bit
// epoch tag instead of a clear: after reset, and after every 15th tensor, a clearing pass over
// min(MAX_CHANNELS, 1024) entries retags every entry, and weights are stalled meanwhile.
// Channel indexes at or above MAX_CHANNELS leave the state alone but their last flag still counts.
// Configuration registers (0 act_min, 1 act_max, 2 accum_count, 3 num_channels) must be
// written only while the block is idle.
module per_channel_range_error_estimator import pcree_pkg::*; #(
	parameter int unsigned MAX_CHANNELS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// configuration writes
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,

	// weight transactions
	input  logic                          weight_valid,
	output logic                          weight_stall,
	input  logic [CH_BITS-1:0]            channel,
	input  logic signed [WEIGHT_BITS-1:0] weight,
	input  logic                          last,

	// result transactions
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [EST_BITS-1:0]           error_estimate,
	output logic [RANGE_BITS-1:0]         range_sum,
	output logic [PEAK_BITS-1:0]          peak_weight
);

	cmd_t cmd;
	sts_t sts;

	// Sequence the read, write-back, multiply and clearing steps.
	pcree_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.weight_valid (weight_valid),
		.weight_stall (weight_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// Hold configuration, channel RAM, accumulators and the result register.
	pcree_dp #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.channel        (channel),
		.weight         (weight),
		.last           (last),
		.result_stall   (result_stall),
		.cmd            (cmd),
		.sts            (sts),
		.result_valid   (result_valid),
		.error_estimate (error_estimate),
		.range_sum      (range_sum),
		.peak_weight    (peak_weight)
	);

endmodule

/* hw/rtl/pcree_ram.sv */
module pcree_ram #(
	parameter int unsigned WIDTH = 36,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/pcree_ctrl.sv */
module pcree_ctrl import pcree_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic weight_valid,
	output logic weight_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		S_SWEEP  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_UPDATE = 8'b0000_0100,
		S_MUL1   = 8'b0000_1000,
		S_MUL2   = 8'b0001_0000,
		S_SUM    = 8'b0010_0000,
		S_MUL3   = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		weight_stall = 1'b1;
		unique case (state_q)
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				weight_stall = 1'b0;
				cmd.accept   = weight_valid;
				if (weight_valid) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = sts.last_item ? S_MUL1 : S_IDLE;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				// hold until the result register is free
				cmd.load = sts.out_free;
				if (sts.out_free) begin
					state_d = sts.epoch_wrap ? S_SWEEP : S_IDLE;
				end
			end
			default: begin
				state_d = S_SWEEP;
			end
		endcase
	end

endmodule

/* hw/rtl/pcree_dp.sv */
module pcree_dp import pcree_pkg::*; #(
	parameter int unsigned MAX_CHANNELS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [CFG_IDX_BITS-1:0]         cfg_index,
	input  logic [CFG_DATA_BITS-1:0]        cfg_data,
	input  logic [CH_BITS-1:0]              channel,
	input  logic signed [WEIGHT_BITS-1:0]   weight,
	input  logic                            last,
	input  logic                            result_stall,
	input  cmd_t                            cmd,
	output sts_t                            sts,
	output logic                            result_valid,
	output logic [EST_BITS-1:0]             error_estimate,
	output logic [RANGE_BITS-1:0]           range_sum,
	output logic [PEAK_BITS-1:0]            peak_weight
);

	localparam int unsigned CH_SPAN    = 1 << CH_BITS;
	localparam int unsigned DEPTH      = (MAX_CHANNELS < CH_SPAN) ? MAX_CHANNELS : CH_SPAN;
	localparam int unsigned AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned ENTRY_BITS = EPOCH_BITS + 2 * WEIGHT_BITS;
	localparam int unsigned P1_BITS    = RANGE_BITS + ACT_BITS;
	localparam int unsigned P2_BITS    = PEAK_BITS + NCH_BITS;
	localparam int unsigned P3_BITS    = P2_BITS + ACT_BITS;
	localparam int unsigned PART_BITS  = BASE_HALF + ADDS_BITS;
	localparam int unsigned TOTAL_BITS = BASE_BITS + ADDS_BITS;

	// configuration
	logic signed [ACT_BITS-1:0] act_min_q, act_max_q;
	logic [ADDS_BITS-1:0]       adds_q;
	logic [NCH_BITS-1:0]        nch_q;

	// activation terms
	logic [ACT_BITS-1:0] act_max_mag, act_min_mag, act_span;
	logic [ACT_BITS:0]   act_diff;
	logic [ACT_BITS-1:0] act_big_q, act_span_q;

	// item held for the write-back cycle
	logic [AW-1:0]                 ch_s1;
	logic signed [WEIGHT_BITS-1:0] w_s1;
	logic                          last_s1, inr_s1;
	logic                          in_range;

	// entry read-modify-write
	logic [ENTRY_BITS-1:0]         rd_entry, wr_entry;
	logic [EPOCH_BITS-1:0]         rd_tag;
	logic signed [WEIGHT_BITS-1:0] rd_hi, rd_lo, new_hi, new_lo;
	logic                          seen;
	logic [WEIGHT_BITS-1:0]        old_range, new_range, delta, w_mag;
	logic [RANGE_BITS:0]           range_sum_d;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;

	// accumulated state
	logic [RANGE_BITS-1:0] range_total_q;
	logic [PEAK_BITS-1:0]  peak_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [AW-1:0]         sweep_cnt_q;

	// final arithmetic
	logic [P1_BITS-1:0]    p1_q;
	logic [P2_BITS-1:0]    p2_q;
	logic [P3_BITS-1:0]    p3_q;
	logic [BASE_BITS-1:0]  base_q;
	logic [PART_BITS-1:0]  part_lo_q, part_hi_q;
	logic [TOTAL_BITS-1:0] total;
	logic [EST_BITS-1:0]   est;

	logic result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_min_q <= '0;
			act_max_q <= '0;
			adds_q    <= ADDS_RESET;
			nch_q     <= NCH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACT_MIN: act_min_q <= signed'(cfg_data[ACT_BITS-1:0]);
				CFG_ACT_MAX: act_max_q <= signed'(cfg_data[ACT_BITS-1:0]);
				CFG_ADDS:    adds_q    <= cfg_data[ADDS_BITS-1:0];
				CFG_NCH:     nch_q     <= cfg_data[NCH_BITS-1:0];
				default:     adds_q    <= adds_q;
			endcase
		end
	end

	assign act_max_mag = act_max_q[ACT_BITS-1] ? ACT_BITS'(-act_max_q) : ACT_BITS'(act_max_q);
	assign act_min_mag = act_min_q[ACT_BITS-1] ? ACT_BITS'(-act_min_q) : ACT_BITS'(act_min_q);
	assign act_diff    = {act_max_q[ACT_BITS-1], act_max_q} - {act_min_q[ACT_BITS-1], act_min_q};
	assign act_span    = act_diff[ACT_BITS] ? ACT_BITS'(-act_diff) : act_diff[ACT_BITS-1:0];

	always_ff @(posedge clk) begin
		act_big_q  <= (act_max_mag > act_min_mag) ? act_max_mag : act_min_mag;
		act_span_q <= act_span;
	end

	assign in_range = 32'(channel) < MAX_CHANNELS;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_s1   <= channel[AW-1:0];
			w_s1    <= weight;
			last_s1 <= last;
			inr_s1  <= in_range;
		end
	end

	assign rd_tag = rd_entry[ENTRY_BITS-1 -: EPOCH_BITS];
	assign rd_hi  = signed'(rd_entry[2*WEIGHT_BITS-1 -: WEIGHT_BITS]);
	assign rd_lo  = signed'(rd_entry[WEIGHT_BITS-1:0]);
	assign seen   = (rd_tag == epoch_q);

	assign new_lo    = (!seen || (w_s1 < rd_lo)) ? w_s1 : rd_lo;
	assign new_hi    = (!seen || (w_s1 > rd_hi)) ? w_s1 : rd_hi;
	assign old_range = seen ? WEIGHT_BITS'(rd_hi - rd_lo) : '0;
	assign new_range = WEIGHT_BITS'(new_hi - new_lo);
	assign delta     = new_range - old_range;
	assign w_mag     = w_s1[WEIGHT_BITS-1] ? WEIGHT_BITS'(-w_s1) : WEIGHT_BITS'(w_s1);
	assign range_sum_d = (RANGE_BITS + 1)'(range_total_q) + (RANGE_BITS + 1)'(delta);

	assign ram_we    = cmd.sweep || (cmd.update && inr_s1);
	assign ram_waddr = cmd.sweep ? sweep_cnt_q : ch_s1;
	assign wr_entry  = cmd.sweep ? {EPOCH_NONE, {(2 * WEIGHT_BITS){1'b0}}}
	                             : {epoch_q, new_hi, new_lo};

	pcree_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (cmd.accept),
		.raddr (channel[AW-1:0]),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_total_q <= '0;
			peak_q        <= '0;
		end else if (cmd.load) begin
			range_total_q <= '0;
			peak_q        <= '0;
		end else if (cmd.update && inr_s1) begin
			range_total_q <= range_sum_d[RANGE_BITS] ? '1 : range_sum_d[RANGE_BITS-1:0];
			if (w_mag > peak_q) begin
				peak_q <= w_mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q     <= EPOCH_FIRST;
			sweep_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				epoch_q <= (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + 1'b1;
			end
			if (cmd.sweep) begin
				sweep_cnt_q <= sts.sweep_done ? '0 : sweep_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			p1_q <= P1_BITS'(range_total_q * act_big_q);
			p2_q <= P2_BITS'(peak_q * nch_q);
		end
		if (cmd.mul2) begin
			p3_q <= P3_BITS'(p2_q * act_span_q);
		end
		if (cmd.sum) begin
			base_q <= BASE_BITS'(p1_q) + BASE_BITS'(p3_q);
		end
		if (cmd.mul3) begin
			part_lo_q <= PART_BITS'(base_q[BASE_HALF-1:0] * adds_q);
			part_hi_q <= PART_BITS'(base_q[BASE_BITS-1:BASE_HALF] * adds_q);
		end
	end

	assign total = TOTAL_BITS'(part_lo_q) + {part_hi_q, {BASE_HALF{1'b0}}};
	assign est   = (|total[TOTAL_BITS-1:EST_BITS]) ? '1 : total[EST_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			error_estimate <= est;
			range_sum      <= range_total_q;
			peak_weight    <= peak_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load) begin
			result_valid_q <= 1'b1;
		end else if (result_valid_q && !result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid   = result_valid_q;
	assign sts.sweep_done = (sweep_cnt_q == AW'(DEPTH - 1));
	assign sts.last_item  = last_s1;
	assign sts.out_free   = !result_valid_q || !result_stall;
	assign sts.epoch_wrap = (epoch_q == EPOCH_LAST);

endmodule

/* hw/rtl/pcree_checker.sv */
`include "per_channel_range_error_estimator_defines.svh"

module pcree_checker import pcree_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  weight_valid,
	input logic                  weight_stall,
	input logic                  result_valid,
	input logic                  result_stall,
	input logic [EST_BITS-1:0]   error_estimate,
	input logic [RANGE_BITS-1:0] range_sum,
	input logic [PEAK_BITS-1:0]  peak_weight
);

	// a stalled result holds
	`PCREE_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(error_estimate) && $stable(range_sum) && $stable(peak_weight), "stalled result changed")

	// each weight needs a write-back cycle before the next is taken
	`PCREE_ASSERT_NEXT(a_writeback_stall, weight_valid && !weight_stall, weight_stall, "weight taken during write-back")

	// peak magnitude cannot exceed that of the most negative weight
	`PCREE_ASSERT_NOW(a_peak_bound, result_valid, peak_weight <= 16'h8000, "peak weight out of range")

	// no spread and no peak means no error
	`PCREE_ASSERT_NOW(a_zero_estimate, result_valid && range_sum == '0 && peak_weight == '0, error_estimate == '0, "estimate non-zero for empty tensor")

endmodule

bind per_channel_range_error_estimator pcree_checker u_checker (.*);
